[hdl/mahd_pkg.sv]
// mahd_pkg: shared types, constants and lookup tables of the mpeg audio header decoder
// holds the item record that passes from the front end through the queue to the back end
// no dependencies
package mahd_pkg;

   // field widths
   localparam int unsigned HDR_W     = 32;
   localparam int unsigned MODE_W    = 2;
   localparam int unsigned VER_W     = 2;
   localparam int unsigned LAYER_W   = 2;
   localparam int unsigned BR_W      = 19;
   localparam int unsigned SR_W      = 16;
   localparam int unsigned FB_W      = 12;
   localparam int unsigned SPF_W     = 11;
   localparam int unsigned SIDE_W    = 6;
   localparam int unsigned KBPS_W    = 9;
   localparam int unsigned SLOTS_W   = 8;
   localparam int unsigned NUMER_W   = 17;
   localparam int unsigned SRX_W     = 2;

   // reciprocal divider: quotient = (m * recip) >> RECIP_SHIFT
   localparam int unsigned DIVIDEND_W  = 21;
   localparam int unsigned RECIP_W     = 25;
   localparam int unsigned PROD_W      = DIVIDEND_W + RECIP_W;
   localparam int unsigned RECIP_SHIFT = 29;
   localparam logic [RECIP_W-1:0] RECIP_441 = RECIP_W'(1217395);  // ceil(2^29 / 441)
   localparam logic [RECIP_W-1:0] RECIP_48  = RECIP_W'(11184811); // ceil(2^29 / 48)
   localparam logic [RECIP_W-1:0] RECIP_32  = RECIP_W'(16777216); // 2^29 / 32

   // default depth of the queue between front and back end
   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   // mpeg version codes on the result port
   localparam logic [VER_W-1:0] VER_MPEG1  = 2'd0;
   localparam logic [VER_W-1:0] VER_MPEG2  = 2'd1;
   localparam logic [VER_W-1:0] VER_MPEG25 = 2'd2;

   // version id codes in the header
   localparam logic [1:0] ID_MPEG25   = 2'd0;
   localparam logic [1:0] ID_RESERVED = 2'd1;
   localparam logic [1:0] ID_MPEG2    = 2'd2;
   localparam logic [1:0] ID_MPEG1    = 2'd3;

   // layer numbers on the result port
   localparam logic [LAYER_W-1:0] LAYER_NONE  = 2'd0;
   localparam logic [LAYER_W-1:0] LAYER_ONE   = 2'd1;
   localparam logic [LAYER_W-1:0] LAYER_TWO   = 2'd2;
   localparam logic [LAYER_W-1:0] LAYER_THREE = 2'd3;

   // sample rate index codes
   localparam logic [SRX_W-1:0] SRX_44K1 = 2'd0;
   localparam logic [SRX_W-1:0] SRX_48K  = 2'd1;
   localparam logic [SRX_W-1:0] SRX_32K  = 2'd2;

   localparam logic [MODE_W-1:0] MODE_MONO = 2'd3;

   // one classified header on its way to the back end
   typedef struct packed {
      logic               valid_res;
      logic               has_crc;
      logic [MODE_W-1:0]  chan_mode;
      logic [VER_W-1:0]   mpeg_version;
      logic [LAYER_W-1:0] layer_number;
      logic [BR_W-1:0]    bit_rate;
      logic [SR_W-1:0]    sample_rate;
      logic               pad;
      logic [SPF_W-1:0]   frame_samples;
      logic [SIDE_W-1:0]  side_info_bytes;
      logic [SRX_W-1:0]   srx;
      logic [NUMER_W-1:0] numer;   // slots * kbps scaled up by the version rate halving
   } item_type;

   // bitrate table in kbit/s, rows: mpeg-1 layer 1..3, lsf layer 1, lsf layer 2/3
   localparam logic [KBPS_W-1:0] RATE_L1 [16] = '{
      9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
      9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
   localparam logic [KBPS_W-1:0] RATE_L2 [16] = '{
      9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
   localparam logic [KBPS_W-1:0] RATE_L3 [16] = '{
      9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
   localparam logic [KBPS_W-1:0] RATE_LSF1 [16] = '{
      9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
   localparam logic [KBPS_W-1:0] RATE_LSF23 [16] = '{
      9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

   // bitrate in kbit/s from version, layer and index
   function automatic logic [KBPS_W-1:0] rate_kbps(input logic [VER_W-1:0] ver,
                                                   input logic [LAYER_W-1:0] layer,
                                                   input logic [3:0] brx);
      logic [KBPS_W-1:0] kbps;
      kbps = '0;
      if (ver == VER_MPEG1) begin
         case (layer)
            LAYER_ONE:   kbps = RATE_L1[brx];
            LAYER_TWO:   kbps = RATE_L2[brx];
            LAYER_THREE: kbps = RATE_L3[brx];
            default:     kbps = '0;
         endcase
      end else if (layer == LAYER_ONE) begin
         kbps = RATE_LSF1[brx];
      end else begin
         kbps = RATE_LSF23[brx];
      end
      return kbps;
   endfunction

   // sampling frequency in hertz
   function automatic logic [SR_W-1:0] freq_hz(input logic [VER_W-1:0] ver,
                                               input logic [SRX_W-1:0] srx);
      logic [SR_W-1:0] base;
      case (srx)
         SRX_44K1: base = SR_W'(44100);
         SRX_48K:  base = SR_W'(48000);
         SRX_32K:  base = SR_W'(32000);
         default:  base = '0;
      endcase
      return base >> ver;
   endfunction

endpackage

[hdl/mahd_front.sv]
// mahd_front: checks the header word, decodes its fields and looks up the tables
// the result is held in one register until the queue takes it
// depends on mahd_pkg
module mahd_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [mahd_pkg::HDR_W-1:0]  req_header_word,
   output logic                        item_valid,
   input  logic                        item_stall,
   output mahd_pkg::item_type          item
);
   import mahd_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   logic [1:0]         id_code;
   logic [1:0]         layer_code;
   logic [3:0]         brx;
   logic [SRX_W-1:0]   srx;
   logic               accept_hdr;
   logic [VER_W-1:0]   ver;
   logic [LAYER_W-1:0] layer;
   logic [KBPS_W-1:0]  kbps;
   logic [SLOTS_W-1:0] slots;
   logic [NUMER_W+1:0] numer_wide;

   assign id_code    = req_header_word[20:19];
   assign layer_code = req_header_word[18:17];
   assign brx        = req_header_word[15:12];
   assign srx        = req_header_word[11:10];

   // sync pattern and forbidden codes
   always_comb begin
      accept_hdr = (req_header_word[31:21] == 11'h7ff)
                && (layer_code != 2'd0)
                && (brx != 4'hf) && (brx != 4'h0)
                && (srx != 2'd3)
                && (req_header_word[31:16] != 16'hfffe)
                && (id_code != ID_RESERVED);
   end

   // field decode and table lookups
   always_comb begin
      case (id_code)
         ID_MPEG1: ver = VER_MPEG1;
         ID_MPEG2: ver = VER_MPEG2;
         default:  ver = VER_MPEG25;
      endcase
      layer = LAYER_W'(3'd4 - {1'b0, layer_code});
      kbps  = rate_kbps(ver, layer, brx);
      if (layer == LAYER_ONE) begin
         slots = SLOTS_W'(12);
      end else if (layer == LAYER_THREE && ver != VER_MPEG1) begin
         slots = SLOTS_W'(72);
      end else begin
         slots = SLOTS_W'(144);
      end
      // lower sample rates are halved or quartered, so the dividend is doubled or quadrupled instead
      numer_wide = ((NUMER_W+2)'(kbps) * (NUMER_W+2)'(slots)) << ver;

      item_in = '0;
      if (accept_hdr) begin
         item_in.valid_res    = 1'b1;
         item_in.has_crc      = ~req_header_word[16];
         item_in.chan_mode    = req_header_word[7:6];
         item_in.mpeg_version = ver;
         item_in.layer_number = layer;
         item_in.bit_rate     = BR_W'(kbps) * BR_W'(1000);
         item_in.sample_rate  = freq_hz(ver, srx);
         item_in.pad          = req_header_word[9];
         if (layer == LAYER_ONE) begin
            item_in.frame_samples = SPF_W'(384);
         end else if (layer == LAYER_THREE && ver != VER_MPEG1) begin
            item_in.frame_samples = SPF_W'(576);
         end else begin
            item_in.frame_samples = SPF_W'(1152);
         end
         if (ver == VER_MPEG1) begin
            item_in.side_info_bytes = (req_header_word[7:6] == MODE_MONO) ?
                                      SIDE_W'(6'h11) : SIDE_W'(6'h20);
         end else begin
            item_in.side_info_bytes = (req_header_word[7:6] == MODE_MONO) ?
                                      SIDE_W'(6'h09) : SIDE_W'(6'h11);
         end
         item_in.srx   = srx;
         item_in.numer = numer_wide[NUMER_W-1:0];
      end
   end

   // holding register, refilled while the queue takes the old item
   assign req_stall = valid_ff & item_stall;
   assign take      = req_valid & ~req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (~item_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[hdl/mahd_queue.sv]
// mahd_queue: short first-in first-out queue of classified items
// decouples the front end from the back end
// depends on mahd_pkg
module mahd_queue #(
   parameter int unsigned DEPTH = mahd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_stall,
   input  mahd_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_stall,
   output mahd_pkg::item_type pop_item
);
   import mahd_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   item_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_stall = (count_ff == CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid & ~push_stall;
   assign do_pop     = pop_valid & ~pop_stall;
   assign pop_item   = slot_ff[rd_ptr_ff];

   // pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[hdl/mahd_back.sv]
// mahd_back: frame length by reciprocal multiplication, then the result register
// two stages, each advancing when the stage after it has room
// depends on mahd_pkg
module mahd_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              item_valid,
   output logic                              item_stall,
   input  mahd_pkg::item_type                item,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_valid_res,
   output logic                              rsp_has_crc,
   output logic [mahd_pkg::MODE_W-1:0]       rsp_chan_mode,
   output logic [mahd_pkg::VER_W-1:0]        rsp_mpeg_version,
   output logic [mahd_pkg::LAYER_W-1:0]      rsp_layer_number,
   output logic [mahd_pkg::BR_W-1:0]         rsp_bit_rate,
   output logic [mahd_pkg::SR_W-1:0]         rsp_sample_rate,
   output logic [mahd_pkg::FB_W-1:0]         rsp_frame_len,
   output logic [mahd_pkg::SPF_W-1:0]        rsp_frame_samples,
   output logic [mahd_pkg::SIDE_W-1:0]       rsp_side_info_bytes
);
   import mahd_pkg::*;

   // multiply stage
   logic                  mul_valid_ff, mul_valid_in;
   item_type              mul_item_ff;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [DIVIDEND_W-1:0] dividend;
   logic [RECIP_W-1:0]    recip;
   logic                  mul_ready, mul_load;

   // result stage
   logic                  out_valid_ff, out_valid_in;
   item_type              out_item_ff;
   logic [FB_W-1:0]       fb_ff, fb_in;
   logic [FB_W-1:0]       quot;
   logic [FB_W:0]         quot_pad;
   logic                  out_ready, out_load;

   assign out_ready  = ~out_valid_ff | ~rsp_stall;
   assign mul_ready  = ~mul_valid_ff | out_ready;
   assign item_stall = ~mul_ready;
   assign mul_load   = item_valid & mul_ready;
   assign out_load   = mul_valid_ff & out_ready;

   // dividend and reciprocal: 44.1 kHz family divides by 441 after scaling by ten
   always_comb begin
      case (item.srx)
         SRX_44K1: begin
            dividend = DIVIDEND_W'({item.numer, 3'b000}) + DIVIDEND_W'({item.numer, 1'b0});
            recip    = RECIP_441;
         end
         SRX_48K: begin
            dividend = DIVIDEND_W'(item.numer);
            recip    = RECIP_48;
         end
         default: begin
            dividend = DIVIDEND_W'(item.numer);
            recip    = RECIP_32;
         end
      endcase
      prod_in = dividend * recip;
   end

   always_comb begin
      mul_valid_in = mul_valid_ff;
      if (mul_load) begin
         mul_valid_in = 1'b1;
      end else if (out_ready) begin
         mul_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_load) begin
         mul_item_ff <= item;
         prod_ff     <= prod_in;
      end
   end

   // padding and the four-byte slots of layer one
   always_comb begin
      quot     = prod_ff[RECIP_SHIFT +: FB_W];
      quot_pad = {1'b0, quot} + (FB_W+1)'(mul_item_ff.pad);
      if (mul_item_ff.layer_number == LAYER_ONE) begin
         fb_in = FB_W'({quot_pad, 2'b00});
      end else begin
         fb_in = quot_pad[FB_W-1:0];
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_item_ff <= mul_item_ff;
         fb_ff       <= fb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result port
   assign rsp_valid           = out_valid_ff;
   assign rsp_valid_res       = out_item_ff.valid_res;
   assign rsp_has_crc         = out_item_ff.has_crc;
   assign rsp_chan_mode       = out_item_ff.chan_mode;
   assign rsp_mpeg_version    = out_item_ff.mpeg_version;
   assign rsp_layer_number    = out_item_ff.layer_number;
   assign rsp_bit_rate        = out_item_ff.bit_rate;
   assign rsp_sample_rate     = out_item_ff.sample_rate;
   assign rsp_frame_len       = fb_ff;
   assign rsp_frame_samples   = out_item_ff.frame_samples;
   assign rsp_side_info_bytes = out_item_ff.side_info_bytes;

endmodule

[hdl/mpeg_audio_header_decode_core.sv]
// channel  | direction | handshake          | payload
// req      | in        | req_valid/req_stall | req_header_word
// rsp      | out       | rsp_valid/rsp_stall | rsp_valid_res .. rsp_side_info_bytes
//
// one header item per cycle sustained while rsp_stall is low
// each item gives one result item, which passes through four
// registers: front register, queue, multiply stage of the frame length divider,
// result register
// reset is synchronous and clears only the valid flags, queue pointers and queue count
// a result-side stall fills the back end, queue, front register, then holds req_stall
//
// mpeg_audio_header_decode_core: top level, front end, queue and back end
// depends on mahd_pkg, mahd_front, mahd_queue, mahd_back
module mpeg_audio_header_decode_core #(
   parameter int unsigned QUEUE_DEPTH = mahd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [mahd_pkg::HDR_W-1:0]        req_header_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_valid_res,
   output logic                              rsp_has_crc,
   output logic [mahd_pkg::MODE_W-1:0]       rsp_chan_mode,
   output logic [mahd_pkg::VER_W-1:0]        rsp_mpeg_version,
   output logic [mahd_pkg::LAYER_W-1:0]      rsp_layer_number,
   output logic [mahd_pkg::BR_W-1:0]         rsp_bit_rate,
   output logic [mahd_pkg::SR_W-1:0]         rsp_sample_rate,
   output logic [mahd_pkg::FB_W-1:0]         rsp_frame_len,
   output logic [mahd_pkg::SPF_W-1:0]        rsp_frame_samples,
   output logic [mahd_pkg::SIDE_W-1:0]       rsp_side_info_bytes
);
   import mahd_pkg::*;

   logic     front_valid, front_stall;
   item_type front_item;
   logic     back_valid, back_stall;
   item_type back_item;

   // header check and table lookups
   mahd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_header_word (req_header_word),
      .item_valid      (front_valid),
      .item_stall      (front_stall),
      .item            (front_item)
   );

   // item queue between the two halves
   mahd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_stall (front_stall),
      .push_item  (front_item),
      .pop_valid  (back_valid),
      .pop_stall  (back_stall),
      .pop_item   (back_item)
   );

   // frame length and result register
   mahd_back u_back (
      .clock               (clock),
      .reset               (reset),
      .item_valid          (back_valid),
      .item_stall          (back_stall),
      .item                (back_item),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_valid_res       (rsp_valid_res),
      .rsp_has_crc         (rsp_has_crc),
      .rsp_chan_mode       (rsp_chan_mode),
      .rsp_mpeg_version    (rsp_mpeg_version),
      .rsp_layer_number    (rsp_layer_number),
      .rsp_bit_rate        (rsp_bit_rate),
      .rsp_sample_rate     (rsp_sample_rate),
      .rsp_frame_len       (rsp_frame_len),
      .rsp_frame_samples   (rsp_frame_samples),
      .rsp_side_info_bytes (rsp_side_info_bytes)
   );

endmodule
